[hdl/lpc_pkg.sv]
`default_nettype none
package lpc_pkg;

  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = 28;
  localparam int COEF_W   = 24;
  localparam int ERR_W    = 27;
  localparam int MUL_W    = 28;
  localparam int PROD_W   = 56;
  localparam int NUM_W    = 57;
  localparam int DCNT_W   = 6;
  localparam int IDXO_W   = 4;
  localparam int FQ_W     = 17;

  localparam logic signed [SUM_W-1:0]  SUM_MAX  = 28'sh7FFFFFF;
  localparam logic signed [SUM_W-1:0]  SUM_MIN  = -28'sh8000000;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = -24'sh800000;
  localparam logic signed [COEF_W-1:0] ONE_Q16  = 24'sh010000;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MAC,
    F_PUSH
  } front_state_e;

  typedef enum logic [4:0] {
    B_IDLE,
    B_INIT,
    B_XM,
    B_XA,
    B_DSET,
    B_DIV,
    B_DEND,
    B_URD1,
    B_URD2,
    B_UM1,
    B_UW1,
    B_UM2,
    B_UW2,
    B_EM,
    B_EF,
    B_EE,
    B_EW,
    B_NEXT,
    B_OUT
  } back_state_e;

  // floor((v + 2^15) / 2^16)
  function automatic logic signed [39:0] rnd_q16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + 56'sd32768;
    return t[PROD_W-1:16];
  endfunction

  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [40:0] v);
    if (v > 41'(COEF_MAX)) begin
      return COEF_MAX;
    end else if (v < 41'(COEF_MIN)) begin
      return COEF_MIN;
    end
    return v[COEF_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    if (v > (SUM_W+1)'(SUM_MAX)) begin
      return SUM_MAX;
    end else if (v < (SUM_W+1)'(SUM_MIN)) begin
      return SUM_MIN;
    end
    return v[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/lpc_front.sv]
`default_nettype none
module lpc_front #(
  parameter int ORDER         = 8,
  parameter int MAX_FRAME_LEN = 4096
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic signed [lpc_pkg::SAMPLE_W-1:0]     sample_i,
  input  wire logic                                    last_sample_i,
  input  wire logic                                    q_full_i,
  output logic                                         push_o,
  output logic signed [lpc_pkg::SUM_W-1:0]             sums_o [ORDER+1]
);

  localparam int K_W   = $clog2(ORDER + 1);
  localparam int H_W   = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

  lpc_pkg::front_state_e state_q, state_d;
  logic [K_W-1:0]   lag_q, lag_d;
  logic [CNT_W-1:0] cnt_q;
  logic signed [lpc_pkg::SAMPLE_W-1:0] s_q;
  logic last_q;
  logic signed [lpc_pkg::SAMPLE_W-1:0] hist_q [ORDER];
  logic signed [lpc_pkg::SUM_W-1:0]    sums_q [ORDER+1];

  logic take, sum_we, finish, clr;
  logic [K_W-1:0] lm1;
  logic signed [lpc_pkg::SAMPLE_W-1:0] hv;
  logic signed [15:0] prod;
  logic signed [lpc_pkg::SUM_W:0] acc;
  logic add_en;

  assign busy   = (state_q != lpc_pkg::F_IDLE);
  assign sums_o = sums_q;

  assign lm1    = lag_q - 1'b1;
  assign hv     = (lag_q == '0) ? s_q : hist_q[lm1[H_W-1:0]];
  assign prod   = s_q * hv;
  assign acc    = (lpc_pkg::SUM_W+1)'(sums_q[lag_q]) + (lpc_pkg::SUM_W+1)'(prod);
  assign add_en = (lag_q == '0) || (cnt_q >= CNT_W'(lag_q));

  always_comb begin
    state_d = state_q;
    lag_d   = lag_q;
    take    = 1'b0;
    sum_we  = 1'b0;
    finish  = 1'b0;
    clr     = 1'b0;
    push_o  = 1'b0;
    case (state_q)
      lpc_pkg::F_IDLE: begin
        if (start) begin
          take  = 1'b1;
          lag_d = '0;
          if (cnt_q < CNT_W'(MAX_FRAME_LEN)) begin
            state_d = lpc_pkg::F_MAC;
          end else if (last_sample_i) begin
            state_d = lpc_pkg::F_PUSH;
          end
        end
      end
      lpc_pkg::F_MAC: begin
        sum_we = add_en;
        if (lag_q == K_W'(ORDER)) begin
          finish  = 1'b1;
          state_d = last_q ? lpc_pkg::F_PUSH : lpc_pkg::F_IDLE;
        end else begin
          lag_d = lag_q + 1'b1;
        end
      end
      lpc_pkg::F_PUSH: begin
        // hold the frame until the buffer frees up
        if (!q_full_i) begin
          push_o  = 1'b1;
          clr     = 1'b1;
          state_d = lpc_pkg::F_IDLE;
        end
      end
      default: state_d = lpc_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpc_pkg::F_IDLE;
      lag_q   <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      s_q     <= '0;
      for (int n = 0; n < ORDER; n++) hist_q[n] <= '0;
      for (int n = 0; n <= ORDER; n++) sums_q[n] <= '0;
    end else begin
      state_q <= state_d;
      lag_q   <= lag_d;
      if (take) begin
        s_q    <= sample_i;
        last_q <= last_sample_i;
      end
      if (sum_we) sums_q[lag_q] <= lpc_pkg::sat_sum(acc);
      if (finish) begin
        for (int n = ORDER - 1; n > 0; n--) hist_q[n] <= hist_q[n-1];
        hist_q[0] <= s_q;
        cnt_q     <= cnt_q + 1'b1;
      end
      if (clr) begin
        cnt_q <= '0;
        for (int n = 0; n < ORDER; n++) hist_q[n] <= '0;
        for (int n = 0; n <= ORDER; n++) sums_q[n] <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/lpc_frame_q.sv]
`default_nettype none
module lpc_frame_q #(
  parameter int ORDER = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  push_i,
  input  wire logic signed [lpc_pkg::SUM_W-1:0]      data_i [ORDER+1],
  input  wire logic                                  pop_i,
  input  wire logic [$clog2(ORDER+1)-1:0]            rd_idx_i,
  output logic                                       valid_o,
  output logic signed [lpc_pkg::SUM_W-1:0]           rd_data_o
);

  logic valid_q;
  logic signed [lpc_pkg::SUM_W-1:0] r_q [ORDER+1];

  assign valid_o   = valid_q;
  assign rd_data_o = r_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) r_q <= data_i;
  end

endmodule
`default_nettype wire

[hdl/lpc_back.sv]
`default_nettype none
module lpc_back #(
  parameter int ORDER = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  q_valid_i,
  input  wire logic signed [lpc_pkg::SUM_W-1:0]      r_data_i,
  output logic [$clog2(ORDER+1)-1:0]                 r_idx_o,
  output logic                                       pop_o,
  output logic                                       result_valid_o,
  output logic [lpc_pkg::IDXO_W-1:0]                 coeff_index_o,
  output logic signed [lpc_pkg::SUM_W-1:0]           autocorrelation_o,
  output logic signed [lpc_pkg::COEF_W-1:0]          lpc_coefficient_o,
  output logic                                       zero_energy_o,
  output logic                                       last_o
);

  localparam int K_W = $clog2(ORDER + 1);
  localparam int NW  = lpc_pkg::NUM_W;
  localparam int CW  = lpc_pkg::COEF_W;

  lpc_pkg::back_state_e state_q, state_d;
  logic [K_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [lpc_pkg::ERR_W-1:0] err_q, err_d;
  logic signed [NW-1:0] acc_q, acc_d;
  logic signed [lpc_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [NW-1:0] dv_q, dv_d;
  logic [lpc_pkg::ERR_W-1:0] rem_q, rem_d;
  logic [lpc_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d;
  logic signed [CW-1:0] p_q, p_d, hj_q, hj_d, hk_q, hk_d;
  logic [lpc_pkg::FQ_W-1:0] f_q, f_d;
  logic zero_q, zero_d;

  logic signed [CW-1:0] coef_q [ORDER+1];
  logic [K_W-1:0] a_ridx, a_widx;
  logic a_we;
  logic signed [CW-1:0] a_wdata, a_rd;

  logic signed [lpc_pkg::MUL_W-1:0] mul_a, mul_b;
  logic signed [lpc_pkg::PROD_W-1:0] mul_p;

  logic [K_W-1:0] imj;
  logic signed [NW-1:0] num;
  logic [NW-1:0] mag;
  logic [lpc_pkg::ERR_W:0] rem_sh;
  logic ge;
  logic signed [39:0] rv;
  logic signed [40:0] fv;
  logic [K_W+1:0] jn2;

  logic out_v_d;
  logic out_v_q;
  logic [lpc_pkg::IDXO_W-1:0] out_k_q;
  logic signed [lpc_pkg::SUM_W-1:0] out_r_q;
  logic signed [CW-1:0] out_c_q;
  logic out_z_q, out_l_q;

  assign imj   = i_q - j_q;
  assign a_rd  = coef_q[a_ridx];
  assign mul_p = mul_a * mul_b;
  assign num   = (NW'(r_data_i) <<< 16) - acc_q;
  assign mag   = num[NW-1] ? NW'(-num) : NW'(num);
  assign rem_sh = {rem_q, dv_q[NW-1]};
  assign ge    = rem_sh >= {1'b0, err_q};
  assign rv    = lpc_pkg::rnd_q16(prod_q);
  assign fv    = 41'sd65536 - 41'(rv);
  assign jn2   = ((K_W+2)'(j_q) + (K_W+2)'(1)) << 1;

  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    err_d = err_q; acc_d = acc_q; prod_d = prod_q;
    dv_d = dv_q; rem_d = rem_q; cnt_d = cnt_q; neg_d = neg_q;
    p_d = p_q; hj_d = hj_q; hk_d = hk_q; f_d = f_q; zero_d = zero_q;
    r_idx_o = '0;
    a_ridx  = j_q;
    a_widx  = i_q;
    a_we    = 1'b0;
    a_wdata = p_q;
    mul_a   = lpc_pkg::MUL_W'(p_q);
    mul_b   = lpc_pkg::MUL_W'(p_q);
    pop_o   = 1'b0;
    out_v_d = 1'b0;
    case (state_q)
      lpc_pkg::B_IDLE: begin
        if (q_valid_i) state_d = lpc_pkg::B_INIT;
      end
      lpc_pkg::B_INIT: begin
        r_idx_o = '0;
        err_d   = (r_data_i > 0) ? r_data_i[lpc_pkg::ERR_W-1:0] : '0;
        zero_d  = (r_data_i == '0);
        i_d     = K_W'(1);
        j_d     = K_W'(1);
        acc_d   = '0;
        state_d = lpc_pkg::B_DSET;
      end
      lpc_pkg::B_XM: begin
        r_idx_o = imj;
        a_ridx  = j_q;
        mul_a   = lpc_pkg::MUL_W'(a_rd);
        mul_b   = r_data_i;
        prod_d  = mul_p;
        state_d = lpc_pkg::B_XA;
      end
      lpc_pkg::B_XA: begin
        acc_d = acc_q + NW'(prod_q);
        j_d   = j_q + 1'b1;
        state_d = ((j_q + 1'b1) < i_q) ? lpc_pkg::B_XM : lpc_pkg::B_DSET;
      end
      lpc_pkg::B_DSET: begin
        r_idx_o = i_q;
        if (err_q == '0) begin
          // no error left: coefficient is zero and the rest stays put
          a_we    = 1'b1;
          a_wdata = '0;
          state_d = lpc_pkg::B_NEXT;
        end else begin
          neg_d   = num[NW-1];
          dv_d    = mag + NW'(err_q >> 1);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = lpc_pkg::B_DIV;
        end
      end
      lpc_pkg::B_DIV: begin
        rem_d = ge ? lpc_pkg::ERR_W'(rem_sh - {1'b0, err_q})
                   : rem_sh[lpc_pkg::ERR_W-1:0];
        dv_d  = {dv_q[NW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == lpc_pkg::DCNT_W'(NW - 1)) state_d = lpc_pkg::B_DEND;
      end
      lpc_pkg::B_DEND: begin
        if (neg_q) begin
          p_d = (dv_q > NW'(24'h800000)) ? lpc_pkg::COEF_MIN : -$signed(dv_q[CW-1:0]);
        end else begin
          p_d = (dv_q > NW'(24'h7FFFFF)) ? lpc_pkg::COEF_MAX : $signed(dv_q[CW-1:0]);
        end
        a_we    = 1'b1;
        a_wdata = p_d;
        j_d     = K_W'(1);
        state_d = (i_q > K_W'(1)) ? lpc_pkg::B_URD1 : lpc_pkg::B_EM;
      end
      lpc_pkg::B_URD1: begin
        a_ridx  = j_q;
        hj_d    = a_rd;
        state_d = lpc_pkg::B_URD2;
      end
      lpc_pkg::B_URD2: begin
        a_ridx  = imj;
        hk_d    = a_rd;
        state_d = lpc_pkg::B_UM1;
      end
      lpc_pkg::B_UM1: begin
        mul_b   = lpc_pkg::MUL_W'(hk_q);
        prod_d  = mul_p;
        state_d = lpc_pkg::B_UW1;
      end
      lpc_pkg::B_UW1: begin
        a_we    = 1'b1;
        a_widx  = j_q;
        a_wdata = lpc_pkg::sat_coef(41'(hj_q) - 41'(rv));
        if (j_q != imj) begin
          state_d = lpc_pkg::B_UM2;
        end else if (jn2 <= (K_W+2)'(i_q)) begin
          j_d = j_q + 1'b1;
          state_d = lpc_pkg::B_URD1;
        end else begin
          state_d = lpc_pkg::B_EM;
        end
      end
      lpc_pkg::B_UM2: begin
        mul_b   = lpc_pkg::MUL_W'(hj_q);
        prod_d  = mul_p;
        state_d = lpc_pkg::B_UW2;
      end
      lpc_pkg::B_UW2: begin
        a_we    = 1'b1;
        a_widx  = imj;
        a_wdata = lpc_pkg::sat_coef(41'(hk_q) - 41'(rv));
        if (jn2 <= (K_W+2)'(i_q)) begin
          j_d = j_q + 1'b1;
          state_d = lpc_pkg::B_URD1;
        end else begin
          state_d = lpc_pkg::B_EM;
        end
      end
      lpc_pkg::B_EM: begin
        prod_d  = mul_p;
        state_d = lpc_pkg::B_EF;
      end
      lpc_pkg::B_EF: begin
        if (fv <= 0) begin
          err_d   = '0;
          state_d = lpc_pkg::B_NEXT;
        end else begin
          f_d     = fv[lpc_pkg::FQ_W-1:0];
          state_d = lpc_pkg::B_EE;
        end
      end
      lpc_pkg::B_EE: begin
        mul_a   = lpc_pkg::MUL_W'({1'b0, err_q});
        mul_b   = lpc_pkg::MUL_W'({1'b0, f_q});
        prod_d  = mul_p;
        state_d = lpc_pkg::B_EW;
      end
      lpc_pkg::B_EW: begin
        err_d   = prod_q[lpc_pkg::ERR_W+15:16];
        state_d = lpc_pkg::B_NEXT;
      end
      lpc_pkg::B_NEXT: begin
        acc_d = '0;
        j_d   = K_W'(1);
        k_d   = '0;
        if (i_q == K_W'(ORDER)) begin
          state_d = lpc_pkg::B_OUT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = lpc_pkg::B_XM;
        end
      end
      lpc_pkg::B_OUT: begin
        r_idx_o = k_q;
        a_ridx  = k_q;
        out_v_d = 1'b1;
        if (k_q == K_W'(ORDER)) begin
          pop_o   = 1'b1;
          state_d = lpc_pkg::B_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: state_d = lpc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpc_pkg::B_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    p_q    <= p_d;
    hj_q   <= hj_d;
    hk_q   <= hk_d;
    f_q    <= f_d;
    zero_q <= zero_d;
    if (a_we) coef_q[a_widx] <= a_wdata;
    if (out_v_d) begin
      out_k_q <= lpc_pkg::IDXO_W'(k_q);
      out_r_q <= r_data_i;
      out_c_q <= (k_q == '0) ? lpc_pkg::ONE_Q16 : (zero_q ? '0 : a_rd);
      out_z_q <= zero_q;
      out_l_q <= (k_q == K_W'(ORDER));
    end
  end

  assign result_valid_o    = out_v_q;
  assign coeff_index_o     = out_k_q;
  assign autocorrelation_o = out_r_q;
  assign lpc_coefficient_o = out_c_q;
  assign zero_energy_o     = out_z_q;
  assign last_o            = out_l_q;

endmodule
`default_nettype wire

[hdl/lpc_autocorrelation_levinson_unit.sv]
// LPC analysis of order ORDER. One signed sample word is taken per start while busy is low;
// each sample runs through a single shared multiply-accumulate, one lag per cycle. On the
// flagged last sample the lag sums move into a one-frame buffer and the next frame starts
// accumulating at once. The Levinson-Durbin unit works from that buffer: each order step runs
// the inner products, a bit-serial division and the coefficient update and error scaling;
// after the last step ORDER+1 results follow on consecutive cycles, one per cycle with
// result_valid_o high. The receiver cannot hold results off. The last sample of a following
// frame keeps busy high until the buffer is free. No clearing pass after reset.
`default_nettype none
module lpc_autocorrelation_levinson_unit #(
  parameter int ORDER         = 8,
  parameter int MAX_FRAME_LEN = 4096
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [lpc_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire logic                                 last_sample_i,
  output logic                                      result_valid_o,
  output logic [lpc_pkg::IDXO_W-1:0]                coeff_index_o,
  output logic signed [lpc_pkg::SUM_W-1:0]          autocorrelation_o,
  output logic signed [lpc_pkg::COEF_W-1:0]         lpc_coefficient_o,
  output logic                                      zero_energy_o,
  output logic                                      last_o
);

  localparam int K_W = $clog2(ORDER + 1);

  logic push, pop, q_valid;
  logic signed [lpc_pkg::SUM_W-1:0] sums [ORDER+1];
  logic [K_W-1:0] r_idx;
  logic signed [lpc_pkg::SUM_W-1:0] r_data;

  lpc_front #(.ORDER(ORDER), .MAX_FRAME_LEN(MAX_FRAME_LEN)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .q_full_i      (q_valid),
    .push_o        (push),
    .sums_o        (sums)
  );

  lpc_frame_q #(.ORDER(ORDER)) u_frame_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .data_i    (sums),
    .pop_i     (pop),
    .rd_idx_i  (r_idx),
    .valid_o   (q_valid),
    .rd_data_o (r_data)
  );

  lpc_back #(.ORDER(ORDER)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .r_data_i          (r_data),
    .r_idx_o           (r_idx),
    .pop_o             (pop),
    .result_valid_o    (result_valid_o),
    .coeff_index_o     (coeff_index_o),
    .autocorrelation_o (autocorrelation_o),
    .lpc_coefficient_o (lpc_coefficient_o),
    .zero_energy_o     (zero_energy_o),
    .last_o            (last_o)
  );

  a_push_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_valid) else $error("frame pushed into a full buffer");

  a_result_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(q_valid)) else $error("result without a buffered frame");

  a_frame_ends_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o) else $error("result after last word");

  a_last_on_top_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> (coeff_index_o == lpc_pkg::IDXO_W'(ORDER)))
    else $error("last flag on the wrong index");

endmodule
`default_nettype wire
